@@ design/sha256_pkg.sv @@
//------------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants and round helper functions.
//------------------------------------------------------------------------------
package sha256_pkg;

   typedef struct packed {
      logic       byte_present;
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } rsp_word_type;

   // queued command from front to back
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data;
      logic       finish;
   } cmd_type;

   typedef logic [31:0] word_type;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int         LEN_POS    = 56;
   localparam int         BLOCK_SIZE = 64;

   function automatic word_type rotr(word_type x, int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type ssig0(word_type x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(word_type x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

@@ design/sha256_if.sv @@
//------------------------------------------------------------------------------
// Stream channel interface
// valid/ready handshake with a generic payload.
//------------------------------------------------------------------------------
interface sha256_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ design/sha256_ram.sv @@
//------------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
//------------------------------------------------------------------------------
module sha256_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ design/sha256_front.sv @@
//------------------------------------------------------------------------------
// SHA-256 front end
// Accepts request words, drops idle ones, and queues commands for the core.
//------------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   sha256_if.sink  req,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);
   localparam int DEPTH = 4;

   cmd_type             q_ff [DEPTH];
   logic [1:0]          wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                push;
   logic                acc;

   assign req.ready = (cnt_ff != 3'(DEPTH));
   assign acc       = req.valid && req.ready;
   // idle words carry nothing and are dropped here
   assign push      = acc && (req.data.byte_present || req.data.end_of_message);

   assign cmd_valid = (cnt_ff != 3'd0);
   assign cmd_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff + 2'(push);
      rp_in  = rp_ff + 2'(cmd_pop);
      cnt_in = cnt_ff + 3'(push) - 3'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= '{has_byte: req.data.byte_present, data: req.data.data_byte,
                          finish: req.data.end_of_message};
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'(DEPTH) |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(DEPTH)) else $error("queue count out of range");
`endif
endmodule

@@ design/sha256_core.sv @@
//------------------------------------------------------------------------------
// SHA-256 back end
// Block buffer, padding sequencer, one round per cycle and digest output.
//------------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd_data,
   output logic     cmd_pop,
   sha256_if.source rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_PAD, S_ZERO, S_LEN, S_LOAD, S_ROUND, S_ADD, S_OUT
   } state_type;

   state_type   state_ff;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [63:0] bits_ff;
   logic [6:0]  rnd_ff;      // load index then round counter
   logic [5:0]  fill_ff;     // padding write pointer
   logic        last_ff;     // compressing the final block
   logic        pad_done_ff; // pad byte still pending after this block
   logic        len_blk_ff;  // zero fill ends at the length field
   logic [2:0]  oidx_ff;

   // block buffer
   logic        wr_en;
   logic [5:0]  wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;

   sha256_ram #(.WIDTH(8), .DEPTH(BLOCK_SIZE)) u_buf (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic [5:0] pos;
   assign pos = bits_ff[8:3];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos;
      wr_data = cmd_data.data;
      unique case (state_ff)
         S_IDLE: wr_en = cmd_valid && cmd_data.has_byte;
         S_PAD: begin
            wr_en = 1'b1; wr_data = PAD_BYTE;
         end
         S_ZERO: begin
            wr_en = 1'b1; wr_addr = fill_ff; wr_data = 8'h00;
         end
         S_LEN: begin
            wr_en   = 1'b1;
            wr_addr = fill_ff;
            wr_data = bits_ff[8*(7 - fill_ff[2:0]) +: 8];
         end
         default: ;
      endcase
   end

   // read one byte per cycle during load; 64 reads, read data registered
   assign rd_addr = rnd_ff[5:0];
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   logic [5:0] ld_idx;
   assign ld_idx = rnd_ff[5:0] - 6'd1;

   word_type w_new, t1, t2, w_cur;
   always_comb begin
      w_new = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
      w_cur = (rnd_ff < 7'd16) ? w_ff[rnd_ff[3:0]] : w_new;
      t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[rnd_ff[5:0]] + w_cur;
      t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = '{digest_word: h_ff[oidx_ff], word_index: oidx_ff,
                        digest_last: (oidx_ff == 3'd7)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         bits_ff     <= '0;
         rnd_ff      <= '0;
         fill_ff     <= '0;
         last_ff     <= 1'b0;
         pad_done_ff <= 1'b0;
         len_blk_ff  <= 1'b0;
         oidx_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
      end else begin
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               pad_done_ff <= 1'b0;
               if (cmd_data.has_byte) begin
                  bits_ff <= bits_ff + 64'd8;
                  if (pos == 6'd63) begin
                     last_ff  <= 1'b0;
                     rnd_ff   <= '0;
                     state_ff <= S_LOAD;
                  end
                  if (cmd_data.finish) pad_done_ff <= 1'b1; // pad still pending
               end
               if (cmd_data.finish && !(cmd_data.has_byte && pos == 6'd63))
                  state_ff <= S_PAD;
            end
            S_PAD: begin
               pad_done_ff <= 1'b0;
               len_blk_ff  <= (pos < 6'(LEN_POS));
               fill_ff     <= pos + 6'd1;
               // pad in the last byte: compress now, length goes in the next block
               if (pos == 6'd63) begin
                  last_ff <= 1'b0; rnd_ff <= '0; state_ff <= S_LOAD;
               end else if (pos == 6'd55) state_ff <= S_LEN;
               else state_ff <= S_ZERO;
            end
            S_ZERO: begin
               fill_ff <= fill_ff + 6'd1;
               if (len_blk_ff && fill_ff == 6'd55) state_ff <= S_LEN;
               if (!len_blk_ff && fill_ff == 6'd63) begin
                  last_ff <= 1'b0; rnd_ff <= '0; state_ff <= S_LOAD;
               end
            end
            S_LEN: begin
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  last_ff <= 1'b1; rnd_ff <= '0; state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if (rnd_ff != 7'd0) begin
                  w_ff[ld_idx[5:2]] <= {w_ff[ld_idx[5:2]][23:0], rd_data};
               end
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == 7'd64) begin
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  rnd_ff   <= '0;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               if (rnd_ff >= 7'd16) begin
                  for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
                  w_ff[15] <= w_new;
               end
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff  <= rnd_ff + 7'd1;
               if (rnd_ff == 7'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               rnd_ff <= '0;
               if (last_ff) begin
                  oidx_ff <= '0; state_ff <= S_OUT;
               end else if (pad_done_ff) state_ff <= S_PAD;
               else if (bits_ff[8:3] != 6'd0) begin
                  // block that held the pad: now zero 0..55 then length
                  fill_ff <= '0; len_blk_ff <= 1'b1; state_ff <= S_ZERO;
               end else state_ff <= S_IDLE;
            end
            S_OUT: if (rsp.ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_HASH[i];
                  bits_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> rnd_ff < 7'd64) else $error("round overrun");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(oidx_ff)) else $error("rsp dropped");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == S_IDLE) else $error("pop while busy");
`endif
endmodule

@@ design/sha256_stream_hasher.sv @@
//------------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the digest as eight 32-bit words.
//------------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | byte_present, data_byte, end_of_message
// rsp     | out | digest_word, word_index, digest_last
//
// The core takes a byte while idle; every 64th byte adds a block compression
// (64 buffer reads plus 64 rounds plus one add), serialised by the single
// round unit and the one-byte RAM read port. Message end adds padding writes,
// one or two compressions and eight digest words. Reset is synchronous and
// needs no clearing pass. A four-entry command queue lets the input run ahead.
//------------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
   input logic      clock,
   input logic      reset,
   sha256_if.sink   req,
   sha256_if.source rsp
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   sha256_front u_front (
      .clock, .reset, .req, .cmd_valid, .cmd_data, .cmd_pop
   );

   sha256_core u_core (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop, .rsp
   );
endmodule
